### design/sfm_pkg.sv
// Shared constants, register codes and result type for the substring match finder.
`timescale 1ns / 1ps

package sfm_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_TEXT    = 65536;

  localparam int BYTE_W     = 8;
  localparam int START_W    = 16;
  localparam int LEN_W      = 4;
  localparam int POS_W      = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_BYTES  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LENGTH = 1'd1;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

### design/substring_first_match_finder.sv
// Top level of the streaming first-match substring finder.
`timescale 1ns / 1ps
// Throughput: one text byte per cycle while s_axis_tready is high; the window compare for
// each byte is done in that cycle. A string's result is registered in the result buffer.
// s_axis_tready drops only while two results wait unread (output register and skid both full).
// Reset (rst, synchronous, active high) clears the pattern registers, the byte count, the
// match state, the sampled start offset and both result slots.

module substring_first_match_finder #(
  parameter int MaxPattern = sfm_pkg::MAX_PATTERN,
  parameter int MaxText    = sfm_pkg::MAX_TEXT
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port.
  input  logic                             cfg_wr_en,
  input  logic [sfm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [sfm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Text byte stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,  // text_byte[7:0], start_offset[23:8]
  input  logic                             s_axis_tuser,  // first_of_string
  input  logic                             s_axis_tlast,  // last_of_string
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // match_position[15:0]
  output logic                             m_axis_tuser   // found
);

  localparam int CntW = $clog2(MaxText + 1);
  // Width for position sums: holds count + 1 and start + length without overflow.
  localparam int SumW = ((CntW > sfm_pkg::START_W) ? CntW : sfm_pkg::START_W) + 2;
  localparam int PatW = MaxPattern * sfm_pkg::BYTE_W;

  // Configuration registers. Only the bytes that the window can use are kept.
  logic [PatW-1:0]              pattern;
  logic [sfm_pkg::LEN_W-1:0]    pattern_len;

  // Per-string state.
  logic [CntW-1:0]              count;
  logic [sfm_pkg::START_W-1:0]  saved_start;
  logic                         match_seen;
  logic [sfm_pkg::POS_W-1:0]    first_idx;

  // Input fields.
  logic [sfm_pkg::BYTE_W-1:0]   text_byte;
  logic [sfm_pkg::START_W-1:0]  start_offset;
  logic                         first_of_string;
  logic                         last_of_string;

  logic                         in_xfer;
  logic                         buf_ready;

  // A byte marked first starts from a cleared count and match state and a fresh start offset.
  logic [CntW-1:0]              count_eff;
  logic [sfm_pkg::START_W-1:0]  start_eff;
  logic                         match_eff;
  logic                         counting;
  logic                         shift;

  logic [SumW-1:0]              pos_plus1;
  logic [SumW-1:0]              min_end;
  logic [SumW-1:0]              begin_pos;
  logic                         len_ok;
  logic                         len_hit;
  logic                         new_hit;

  logic [sfm_pkg::BYTE_W-1:0]   chain [MaxPattern+1];
  logic [MaxPattern-1:0]        cell_eq [MaxPattern];
  logic [MaxPattern-1:0]        match_len;

  sfm_pkg::result_t             result;

  assign text_byte       = s_axis_tdata[7:0];
  assign start_offset    = s_axis_tdata[23:8];
  assign first_of_string = s_axis_tuser;
  assign last_of_string  = s_axis_tlast;

  assign s_axis_tready = buf_ready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign count_eff = first_of_string ? '0 : count;
  assign start_eff = first_of_string ? start_offset : saved_start;
  assign match_eff = first_of_string ? 1'b0 : match_seen;
  // Once the count reaches the text limit, later bytes are neither shifted in nor compared.
  assign counting  = (SumW'(count_eff) < SumW'(MaxText));
  assign shift     = in_xfer && counting;

  // Window: a row of byte cells. Cell k holds the k-th newest byte; every transfer below the
  // text limit moves each byte one cell further along, and the text byte enters at cell 0.
  assign chain[0] = text_byte;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    sfm_cell #(
      .MaxPattern(MaxPattern)
    ) u_cell (
      .clk    (clk),
      .shift  (shift),
      .byte_in(chain[k]),
      .pattern(pattern),
      .byte_q (chain[k+1]),
      .eq     (cell_eq[k])
    );
  end

  // A pattern of length L matches when the k-th newest byte equals pattern byte L-1-k for
  // every k below L. All lengths are evaluated, and the configured one is picked below.
  always_comb begin
    for (int l = 1; l <= MaxPattern; l++) begin
      match_len[l-1] = 1'b1;
      for (int k = 0; k < l; k++) begin
        match_len[l-1] = match_len[l-1] & cell_eq[k][l-1-k];
      end
    end
  end

  always_comb begin
    len_hit = 1'b0;
    for (int l = 1; l <= MaxPattern; l++) begin
      if (pattern_len == sfm_pkg::LEN_W'(l)) begin
        len_hit = match_len[l-1];
      end
    end
  end

  // The match must fit in the bytes seen so far and begin at or after the start offset:
  // count + 1 >= start + length covers both. An empty or oversized length never matches.
  assign pos_plus1 = SumW'(count_eff) + SumW'(1);
  assign min_end   = SumW'(start_eff) + SumW'(pattern_len);
  assign begin_pos = pos_plus1 - SumW'(pattern_len);
  assign len_ok    = (pattern_len != '0) &&
                     (SumW'(pattern_len) <= SumW'(MaxPattern));
  assign new_hit   = counting && !match_eff && len_ok && (pos_plus1 >= min_end) && len_hit;

  always_comb begin
    result.found    = match_eff || new_hit;
    result.position = '0;
    if (new_hit) begin
      result.position = begin_pos[sfm_pkg::POS_W-1:0];
    end else if (match_eff) begin
      result.position = first_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern     <= '0;
      pattern_len <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        sfm_pkg::REG_PATTERN_BYTES:  pattern     <= cfg_wdata[PatW-1:0];
        sfm_pkg::REG_PATTERN_LENGTH: pattern_len <= cfg_wdata[sfm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      saved_start <= '0;
      match_seen  <= 1'b0;
      first_idx   <= '0;
    end else if (in_xfer) begin
      saved_start <= start_eff;
      if (last_of_string) begin
        // The string ends here; the next byte starts a new one even without a first mark.
        count      <= '0;
        match_seen <= 1'b0;
        first_idx  <= '0;
      end else begin
        if (counting) begin
          count <= pos_plus1[CntW-1:0];
        end else begin
          count <= count_eff;
        end
        match_seen <= result.found;
        first_idx  <= result.position;
      end
    end
  end

  // Result slots: the output register and a skid register let the text side keep
  // streaming while a result waits to be taken.
  sfm_pkg::result_t out_result;

  sfm_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid && last_of_string),
    .in_ready (buf_ready),
    .in_data  (result),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (out_result)
  );

  assign m_axis_tdata = out_result.position;
  assign m_axis_tuser = out_result.found;

  // A result that reports no match carries position zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("not-found result with nonzero position");

  // The byte count never runs past the text limit.
  assert property (@(posedge clk) disable iff (rst)
    SumW'(count) <= SumW'(MaxText))
    else $error("byte count beyond text limit");

  // The transfer of a last byte leaves the string state cleared.
  assert property (@(posedge clk) disable iff (rst)
    in_xfer && last_of_string |=> count == '0 && !match_seen)
    else $error("string state not cleared after last byte");

  // The text side stalls only while a result waits on the master side.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

endmodule

### design/sfm_cell.sv
// One byte cell of the text window: holds a byte and compares it with every pattern byte.
`timescale 1ns / 1ps

module sfm_cell #(
  parameter int MaxPattern = sfm_pkg::MAX_PATTERN
) (
  input  logic                                  clk,
  input  logic                                  shift,
  input  logic [sfm_pkg::BYTE_W-1:0]            byte_in,
  input  logic [MaxPattern*sfm_pkg::BYTE_W-1:0] pattern,
  output logic [sfm_pkg::BYTE_W-1:0]            byte_q,
  output logic [MaxPattern-1:0]                 eq
);

  // The byte this cell takes on the current transfer is the one compared,
  // so the compare sees the window as it stands after the shift.
  always_comb begin
    for (int j = 0; j < MaxPattern; j++) begin
      eq[j] = (byte_in == pattern[j*sfm_pkg::BYTE_W +: sfm_pkg::BYTE_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_q <= byte_in;
    end
  end

endmodule

### design/sfm_out_buf.sv
// Two-entry result buffer (output register plus skid register) for the match results.
`timescale 1ns / 1ps

module sfm_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfm_pkg::result_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sfm_pkg::result_t out_data
);

  logic             skid_valid;
  sfm_pkg::result_t skid_data;
  logic             push;
  logic             pop;

  assign in_ready = !skid_valid;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      if (push) begin
        out_valid <= 1'b1;
        out_data  <= in_data;
      end
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= in_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      skid_data  <= in_data;
      skid_valid <= 1'b1;
    end
  end

endmodule
